/* sv/lcgs_pkg.sv */
// Package for the LED current gain select block.
// Holds the status codes, fixed constants and the side-band type shared by all files.
package lcgs_pkg;

   localparam int MicroAmpsWidth = 21;
   localparam int CodeWidth      = 12;
   localparam int StatusWidth    = 2;

   localparam logic [StatusWidth-1:0] StatusOk       = 2'd0;
   localparam logic [StatusWidth-1:0] StatusRejected = 2'd1;
   localparam logic [StatusWidth-1:0] StatusNoFit    = 2'd2;

   localparam logic [MicroAmpsWidth-1:0] MinUa = 21'd100;
   localparam logic [MicroAmpsWidth-1:0] MaxUa = 21'd1200000;

   typedef struct packed {
      logic                   gain_a;
      logic                   gain_b;
      logic                   gain_c;
      logic                   range_d;
      logic [StatusWidth-1:0] status;
   } side_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] num;
      logic [32:0] div;
      side_type    side;
   } div_req_type;

   typedef struct packed {
      logic                 valid;
      logic [CodeWidth-1:0] code;
      side_type             side;
   } div_rsp_type;

endpackage

/* sv/lcgs_req_if.sv */
// Request channel interface carrying the target current.
// Depends on lcgs_pkg for the field width.
interface lcgs_req_if;
   logic                                valid;
   logic                                ready;
   logic [lcgs_pkg::MicroAmpsWidth-1:0] micro_amps;

   modport source (output valid, output micro_amps, input ready);
   modport sink (input valid, input micro_amps, output ready);
endinterface

/* sv/lcgs_rsp_if.sv */
// Response channel interface carrying the drive code, gain bits and status.
// Depends on lcgs_pkg for the field widths.
interface lcgs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lcgs_pkg::CodeWidth-1:0]   drive_code;
   logic                             gain_a;
   logic                             gain_b;
   logic                             gain_c;
   logic                             range_d;
   logic [lcgs_pkg::StatusWidth-1:0] status;

   modport source (output valid, output drive_code, output gain_a, output gain_b,
                   output gain_c, output range_d, output status, input ready);
   modport sink (input valid, input drive_code, input gain_a, input gain_b,
                 input gain_c, input range_d, input status, output ready);
endinterface

/* sv/lcgs_divider.sv */
// Pipelined restoring divider producing a saturated 12-bit quotient.
// Depends on lcgs_pkg; one saturation stage then one quotient bit per stage.
module lcgs_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  lcgs_pkg::div_req_type din,
   output lcgs_pkg::div_rsp_type dout
);
   import lcgs_pkg::*;

   localparam int Steps  = CodeWidth;
   localparam int CmpW   = 33 + CodeWidth;

   typedef struct packed {
      logic                 valid;
      logic [31:0]          rem;
      logic [32:0]          div;
      logic [CodeWidth-1:0] quo;
      logic                 sat;
      side_type             side;
   } stage_type;

   stage_type st_ff [0:Steps];
   stage_type st_in [0:Steps];

   always_comb begin
      logic [CmpW-1:0] shifted;
      st_in[0].valid = din.valid;
      st_in[0].rem   = din.num;
      st_in[0].div   = din.div;
      st_in[0].quo   = '0;
      st_in[0].side  = din.side;
      st_in[0].sat   = CmpW'(din.num) >= (CmpW'(din.div) << Steps);
      for (int i = 1; i <= Steps; i++) begin
         st_in[i] = st_ff[i-1];
         shifted  = CmpW'(st_ff[i-1].div) << (Steps - i);
         if (CmpW'(st_ff[i-1].rem) >= shifted) begin
            st_in[i].rem            = st_ff[i-1].rem - shifted[31:0];
            st_in[i].quo[Steps - i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Steps; i++) begin
            st_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         for (int i = 0; i <= Steps; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign dout.valid = st_ff[Steps].valid;
   assign dout.side  = st_ff[Steps].side;
   assign dout.code  = (st_ff[Steps].side.status != StatusOk) ? '0 :
                       st_ff[Steps].sat ? '1 : st_ff[Steps].quo;

endmodule

/* sv/led_current_gain_select.sv */
// LED current gain select: takes a target current in microamps and returns gain bits,
// range bit, a saturated 12-bit drive code and a status. One transaction is accepted
// every clock cycle while the response side is not stalled; a result passes through
// six selection stages and then the thirteen-stage divider that forms the drive code.
// The whole pipeline holds while a result waits, so request ready follows response ready.
// Depends on lcgs_pkg, lcgs_req_if, lcgs_rsp_if and lcgs_divider.
module led_current_gain_select (
   input  logic       clock,
   input  logic       reset,
   lcgs_req_if.sink   req,
   lcgs_rsp_if.source rsp
);
   import lcgs_pkg::*;

   localparam int PW = 35;
   localparam int LW = 40;

   logic en;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Stage 1: clamp and reject.
   logic                      v1_ff, rej1_ff;
   logic [MicroAmpsWidth-1:0] m1_ff;

   // Stage 2: constant products.
   logic                      v2_ff, rej2_ff;
   logic [MicroAmpsWidth-1:0] m2_ff;
   logic [PW-1:0]             p2_ff [0:6];
   logic [LW-1:0]             w2_ff [0:4];

   // Stage 3: candidate gain bits (pass1 narrow, pass1 wide, pass2 narrow, pass2 wide).
   logic                      v3_ff, rej3_ff;
   logic [MicroAmpsWidth-1:0] m3_ff;
   logic [2:0]                g3_ff [0:3];
   logic [2:0]                g3_in [0:3];
   logic [LW-1:0]             w3_ff [0:4];

   // Stage 4: fit flags.
   logic                      v4_ff, rej4_ff;
   logic [MicroAmpsWidth-1:0] m4_ff;
   logic [2:0]                g4_ff [0:3];
   logic [3:0]                f4_ff;
   logic [3:0]                f4_in;

   // Stage 5: selection.
   logic                      v5_ff;
   logic [MicroAmpsWidth-1:0] m5_ff;
   logic [11:0]               den5_ff;
   logic [31:0]               num5_ff;
   side_type                  side5_ff, side5_in;
   logic [11:0]               den5_in;

   // Stage 6: divisor product.
   logic                      v6_ff;
   logic [32:0]               div6_ff;
   logic [31:0]               num6_ff;
   side_type                  side6_ff;

   function automatic logic [2:0] cand_bits(input logic [23:0] n,
                                            input logic [PW-1:0] p [0:6]);
      logic [PW-1:0] nn;
      logic c, b, a;
      nn = PW'(n);
      c  = nn >= p[3];
      b  = c ? (nn >= p[5]) : (nn >= p[1]);
      if (c) begin
         a = b ? (nn >= p[6]) : (nn >= p[4]);
      end else begin
         a = b ? (nn >= p[2]) : (nn >= p[0]);
      end
      return {c, b, a};
   endfunction

   assign en        = !div_rsp.valid || rsp.ready;
   assign req.ready = en;

   always_comb begin
      g3_in[0] = cand_bits(24'd16000000, p2_ff);
      g3_in[1] = cand_bits(24'd8000000, p2_ff);
      g3_in[2] = cand_bits(24'd8000000, p2_ff);
      g3_in[3] = cand_bits(24'd4000000, p2_ff);
   end

   always_comb begin
      logic [LW-1:0] base;
      for (int i = 0; i < 4; i++) begin
         base = (g3_ff[i][2] ? w3_ff[4] : '0) + (g3_ff[i][1] ? w3_ff[3] : '0) +
                (g3_ff[i][0] ? w3_ff[2] : '0);
         if (i[0]) begin
            f4_in[i] = (w3_ff[1] + (base << 1)) < LW'(211000000);
         end else begin
            f4_in[i] = (w3_ff[0] + base) < LW'(211000000);
         end
      end
   end

   always_comb begin
      logic [2:0] g;
      side5_in = '0;
      g        = '0;
      if (rej4_ff) begin
         side5_in.status = StatusRejected;
      end else if (f4_ff[0] || f4_ff[1]) begin
         side5_in.range_d = !f4_ff[1];
         g = f4_ff[1] ? g4_ff[1] : g4_ff[0];
      end else if (f4_ff[2] || f4_ff[3]) begin
         side5_in.range_d = !f4_ff[3];
         g = f4_ff[3] ? g4_ff[3] : g4_ff[2];
      end else begin
         side5_in.status = StatusNoFit;
      end
      if (side5_in.status == StatusOk) begin
         side5_in.gain_c = g[2];
         side5_in.gain_b = g[1];
         side5_in.gain_a = g[0];
      end
      den5_in = 12'd3 + 12'(side5_in.range_d) + (g[2] ? 12'd2000 : 12'd0) +
                (g[1] ? 12'd200 : 12'd0) + (g[0] ? 12'd20 : 12'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff   <= req.valid;
         m1_ff   <= (req.micro_amps < MinUa) ? MinUa : req.micro_amps;
         rej1_ff <= req.micro_amps > MaxUa;

         v2_ff    <= v1_ff;
         rej2_ff  <= rej1_ff;
         m2_ff    <= m1_ff;
         p2_ff[0] <= PW'(m1_ff) * PW'(41);
         p2_ff[1] <= PW'(m1_ff) * PW'(311);
         p2_ff[2] <= PW'(m1_ff) * PW'(1041);
         p2_ff[3] <= PW'(m1_ff) * PW'(5011);
         p2_ff[4] <= PW'(m1_ff) * PW'(10041);
         p2_ff[5] <= PW'(m1_ff) * PW'(10311);
         p2_ff[6] <= PW'(m1_ff) * PW'(11041);
         w2_ff[0] <= LW'(m1_ff) * LW'(200);
         w2_ff[1] <= LW'(m1_ff) * LW'(300);
         w2_ff[2] <= LW'(m1_ff) * LW'(1000);
         w2_ff[3] <= LW'(m1_ff) * LW'(10000);
         w2_ff[4] <= LW'(m1_ff) * LW'(100000);

         v3_ff   <= v2_ff;
         rej3_ff <= rej2_ff;
         m3_ff   <= m2_ff;
         g3_ff   <= g3_in;
         w3_ff   <= w2_ff;

         v4_ff   <= v3_ff;
         rej4_ff <= rej3_ff;
         m4_ff   <= m3_ff;
         g4_ff   <= g3_ff;
         f4_ff   <= f4_in;

         v5_ff    <= v4_ff;
         m5_ff    <= m4_ff;
         side5_ff <= side5_in;
         den5_ff  <= den5_in;
         num5_ff  <= side5_in.range_d ? 32'd3276800000 : 32'd1638400000;

         v6_ff    <= v5_ff;
         div6_ff  <= 33'(m5_ff) * 33'(den5_ff);
         num6_ff  <= num5_ff;
         side6_ff <= side5_ff;
      end
   end

   assign div_req.valid = v6_ff;
   assign div_req.num   = num6_ff;
   assign div_req.div   = div6_ff;
   assign div_req.side  = side6_ff;

   lcgs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   (div_req),
      .dout  (div_rsp)
   );

   assign rsp.valid      = div_rsp.valid;
   assign rsp.drive_code = div_rsp.code;
   assign rsp.gain_a     = div_rsp.side.gain_a;
   assign rsp.gain_b     = div_rsp.side.gain_b;
   assign rsp.gain_c     = div_rsp.side.gain_c;
   assign rsp.range_d    = div_rsp.side.range_d;
   assign rsp.status     = div_rsp.side.status;

endmodule

/* sv/lcgs_checker.sv */
// Port-level checker for the LED current gain select block, bound to the top level.
// Depends on lcgs_pkg for the status codes.
module lcgs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lcgs_pkg::CodeWidth-1:0]   rsp_drive_code,
   input logic                             rsp_gain_a,
   input logic                             rsp_gain_b,
   input logic                             rsp_gain_c,
   input logic                             rsp_range_d,
   input logic [lcgs_pkg::StatusWidth-1:0] rsp_status
);
   import lcgs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the response side");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StatusOk |->
         rsp_drive_code == '0 && !rsp_gain_a && !rsp_gain_b && !rsp_gain_c && !rsp_range_d)
      else $error("failed transaction carries nonzero result fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == StatusOk || rsp_status == StatusRejected ||
                    rsp_status == StatusNoFit)
      else $error("undefined status code");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind led_current_gain_select lcgs_checker u_lcgs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_drive_code (rsp.drive_code),
   .rsp_gain_a     (rsp.gain_a),
   .rsp_gain_b     (rsp.gain_b),
   .rsp_gain_c     (rsp.gain_c),
   .rsp_range_d    (rsp.range_d),
   .rsp_status     (rsp.status)
);
